/* rtl/bct_pkg.sv */
// shared types, constants and helpers of the bracket-checking tokenizer
// used by bct_ctrl, bct_dp and bracket_checking_tokenizer_unit
package bct_pkg;

	localparam int DEF_STACK_DEPTH = 32;
	localparam int DEF_LINE_BITS   = 24;

	localparam int CHAR_W     = 8;
	localparam int EV_W       = 3;
	localparam int LINE_OUT_W = 24;
	localparam int ERR_W      = 16;
	localparam int CFG_W      = 8;
	localparam int IN_TDATA_W  = 8;
	localparam int OUT_TDATA_W = 56;
	localparam int OUT_TUSER_W = 3;

	// event kinds
	localparam logic [EV_W-1:0] EV_TOKEN     = 3'd0;
	localparam logic [EV_W-1:0] EV_INVALID   = 3'd1;
	localparam logic [EV_W-1:0] EV_UNMATCHED = 3'd2;
	localparam logic [EV_W-1:0] EV_UNCLOSED  = 3'd3;
	localparam logic [EV_W-1:0] EV_TOO_MANY  = 3'd4;
	localparam logic [EV_W-1:0] EV_TOO_DEEP  = 3'd5;
	localparam logic [EV_W-1:0] EV_SUMMARY   = 3'd6;

	localparam logic [CHAR_W-1:0] CH_GT    = 8'h3E;
	localparam logic [CHAR_W-1:0] CH_LT    = 8'h3C;
	localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
	localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
	localparam logic [CHAR_W-1:0] CH_OPEN  = 8'h5B;
	localparam logic [CHAR_W-1:0] CH_CLOSE = 8'h5D;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CH_NL    = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_HASH  = 8'h23;
	localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;

	localparam logic [ERR_W-1:0] ERR_MAX = 16'hFFFF;
	localparam logic [CFG_W-1:0] MAX_ERRORS_RESET = 8'd20;

	// controller to datapath
	typedef struct packed {
		logic take_byte;
		logic take_eot;
		logic emit_second;
		logic pop_rd;
		logic emit_unclosed;
		logic emit_summary;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic out_free;
		logic two_results;
		logic halted;
		logic depth_zero;
	} sts_t;

	function automatic logic is_command(input logic [CHAR_W-1:0] c);
		return (c == CH_GT) || (c == CH_LT) || (c == CH_PLUS) || (c == CH_MINUS) ||
			(c == CH_DOT) || (c == CH_COMMA) || (c == CH_OPEN) || (c == CH_CLOSE);
	endfunction

endpackage

/* rtl/bct_ctrl.sv */
// controller of the tokenizer: sequences item intake, second results,
// the end-of-text stack flush and the summary; uses bct_pkg
module bct_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	input  logic          s_tlast,
	output logic          s_tready,
	input  bct_pkg::sts_t sts,
	output bct_pkg::cmd_t cmd
);
	import bct_pkg::*;

	localparam logic [2:0] S_IDLE      = 3'd0;
	localparam logic [2:0] S_SECOND    = 3'd1;
	localparam logic [2:0] S_FLUSH_RD  = 3'd2;
	localparam logic [2:0] S_FLUSH_OUT = 3'd3;
	localparam logic [2:0] S_SUMMARY   = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       accept;

	assign s_tready = (state_q == S_IDLE) && sts.out_free;
	assign accept   = s_tready && s_tvalid;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (s_tlast) begin
						cmd.take_eot = 1'b1;
						if (sts.halted || sts.depth_zero) begin
							state_d = S_SUMMARY;
						end else begin
							state_d = S_FLUSH_RD;
						end
					end else begin
						cmd.take_byte = 1'b1;
						if (sts.two_results) begin
							state_d = S_SECOND;
						end
					end
				end
			end
			S_SECOND: begin
				if (sts.out_free) begin
					cmd.emit_second = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_FLUSH_RD: begin
				cmd.pop_rd = 1'b1;
				state_d = S_FLUSH_OUT;
			end
			S_FLUSH_OUT: begin
				if (sts.out_free) begin
					cmd.emit_unclosed = 1'b1;
					if (sts.depth_zero) begin
						state_d = S_SUMMARY;
					end else begin
						state_d = S_FLUSH_RD;
					end
				end
			end
			S_SUMMARY: begin
				if (sts.out_free) begin
					cmd.emit_summary = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* rtl/bct_dp.sv */
// datapath of the tokenizer: line and error counters, bracket line stack,
// limit register and the output register; uses bct_pkg
module bct_dp #(
	parameter int STACK_DEPTH = bct_pkg::DEF_STACK_DEPTH,
	parameter int LINE_BITS   = bct_pkg::DEF_LINE_BITS
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic [bct_pkg::IN_TDATA_W-1:0]       s_tdata,
	input  logic                                 cfg_valid,
	input  logic [bct_pkg::CFG_W-1:0]            cfg_data,
	input  logic                                 m_tready,
	output logic                                 m_tvalid,
	output logic [bct_pkg::OUT_TDATA_W-1:0]      m_tdata,
	output logic [bct_pkg::OUT_TUSER_W-1:0]      m_tuser,
	output logic                                 m_tlast,
	input  bct_pkg::cmd_t                        cmd,
	output bct_pkg::sts_t                        sts
);
	import bct_pkg::*;

	localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);
	localparam int IDX_W   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};
	localparam logic [LINE_BITS-1:0] LINE_ONE = LINE_BITS'(1);
	localparam logic [DEPTH_W-1:0]   DEPTH_FULL = DEPTH_W'(STACK_DEPTH);

	function automatic logic [LINE_OUT_W-1:0] line_out(input logic [LINE_BITS-1:0] v);
		logic [LINE_BITS+LINE_OUT_W-1:0] ext;
		ext = {{LINE_OUT_W{1'b0}}, v};
		return ext[LINE_OUT_W-1:0];
	endfunction

	// architectural state
	logic                 in_comment_q, halted_q, fail_q;
	logic [LINE_BITS-1:0] line_q;
	logic [ERR_W-1:0]     err_q;
	logic [DEPTH_W-1:0]   depth_q;
	logic [CFG_W-1:0]     max_err_q;
	logic [EV_W-1:0]      sec_ev_q;
	logic [LINE_BITS-1:0] rd_q;
	logic [LINE_BITS-1:0] stack_mem [STACK_DEPTH];

	// output register
	logic                  out_valid_q;
	logic [EV_W-1:0]       ev_q;
	logic [CHAR_W-1:0]     char_q;
	logic [LINE_OUT_W-1:0] oline_q;
	logic [ERR_W-1:0]      oerr_q;
	logic                  ofail_q;
	logic                  olast_q;

	logic [CHAR_W-1:0]  c;
	logic               active, is_cmd, is_ws, invalid, abort, unmatched, full;
	logic [ERR_W-1:0]   err_inc;
	logic [LINE_BITS-1:0] line_inc;
	logic [DEPTH_W-1:0] depth_dec;
	logic               push;

	logic                 in_comment_d, halted_d;
	logic [LINE_BITS-1:0] line_d;
	logic [ERR_W-1:0]     err_d;
	logic [DEPTH_W-1:0]   depth_d;

	logic                  load;
	logic [EV_W-1:0]       ld_ev;
	logic [CHAR_W-1:0]     ld_char;
	logic [LINE_OUT_W-1:0] ld_line;
	logic [ERR_W-1:0]      ld_err;
	logic                  ld_fail, ld_last;

	assign c         = s_tdata[CHAR_W-1:0];
	assign active    = !halted_q && !in_comment_q;
	assign is_cmd    = is_command(c);
	assign is_ws     = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NL);
	assign err_inc   = (err_q == ERR_MAX) ? err_q : err_q + ERR_W'(1);
	assign line_inc  = (line_q == LINE_MAX) ? line_q : line_q + LINE_ONE;
	assign depth_dec = depth_q - DEPTH_W'(1);
	assign full      = (depth_q == DEPTH_FULL);
	assign invalid   = active && !is_cmd && !is_ws && (c != CH_HASH);
	assign abort     = invalid && (err_inc > {{(ERR_W-CFG_W){1'b0}}, max_err_q});
	assign unmatched = active && (c == CH_CLOSE) && (depth_q == '0);

	assign sts.out_free    = !out_valid_q || m_tready;
	assign sts.two_results = unmatched || abort;
	assign sts.halted      = halted_q;
	assign sts.depth_zero  = (depth_q == '0);

	always_comb begin
		in_comment_d = in_comment_q;
		halted_d     = halted_q;
		line_d       = line_q;
		err_d        = err_q;
		depth_d      = depth_q;
		push         = 1'b0;
		load         = 1'b0;
		ld_ev        = EV_TOKEN;
		ld_char      = c;
		ld_line      = line_out(line_q);
		ld_err       = err_q;
		ld_fail      = 1'b0;
		ld_last      = 1'b1;
		if (cmd.take_byte && !halted_q) begin
			if (in_comment_q) begin
				if (c == CH_NL) begin
					line_d       = line_inc;
					in_comment_d = 1'b0;
				end
			end else if (is_cmd) begin
				load = 1'b1;
				if (c == CH_OPEN) begin
					if (full) begin
						err_d    = err_inc;
						ld_err   = err_inc;
						ld_ev    = EV_TOO_DEEP;
						halted_d = 1'b1;
					end else begin
						push    = 1'b1;
						depth_d = depth_q + DEPTH_W'(1);
					end
				end else if (c == CH_CLOSE) begin
					if (unmatched) begin
						err_d   = err_inc;
						ld_last = 1'b0;
					end else begin
						depth_d = depth_dec;
					end
				end
			end else if (c == CH_NL) begin
				line_d = line_inc;
			end else if (c == CH_HASH) begin
				in_comment_d = 1'b1;
			end else if (invalid) begin
				load     = 1'b1;
				err_d    = err_inc;
				ld_err   = err_inc;
				ld_ev    = EV_INVALID;
				ld_last  = !abort;
				halted_d = abort;
			end
		end
		if (cmd.emit_second) begin
			// char and line stay from the first result of the item
			load    = 1'b1;
			ld_ev   = sec_ev_q;
			ld_char = char_q;
			ld_line = oline_q;
		end
		if (cmd.pop_rd) begin
			depth_d = depth_dec;
		end
		if (cmd.emit_unclosed) begin
			load    = 1'b1;
			ld_ev   = EV_UNCLOSED;
			ld_char = CH_OPEN;
			ld_line = line_out(rd_q);
			ld_last = 1'b0;
		end
		if (cmd.emit_summary) begin
			load         = 1'b1;
			ld_ev        = EV_SUMMARY;
			ld_char      = CH_NUL;
			ld_fail      = fail_q;
			in_comment_d = 1'b0;
			halted_d     = 1'b0;
			line_d       = LINE_ONE;
			err_d        = '0;
			depth_d      = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_comment_q <= 1'b0;
			halted_q     <= 1'b0;
			line_q       <= LINE_ONE;
			err_q        <= '0;
			depth_q      <= '0;
			max_err_q    <= MAX_ERRORS_RESET;
			fail_q       <= 1'b0;
			sec_ev_q     <= EV_UNMATCHED;
			out_valid_q  <= 1'b0;
		end else begin
			in_comment_q <= in_comment_d;
			halted_q     <= halted_d;
			line_q       <= line_d;
			err_q        <= err_d;
			depth_q      <= depth_d;
			if (cfg_valid) begin
				max_err_q <= cfg_data;
			end
			if (cmd.take_eot) begin
				fail_q <= halted_q || (err_q != '0) || (depth_q != '0);
			end
			if (cmd.take_byte) begin
				sec_ev_q <= unmatched ? EV_UNMATCHED : EV_TOO_MANY;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			ev_q    <= ld_ev;
			char_q  <= ld_char;
			oline_q <= ld_line;
			oerr_q  <= ld_err;
			ofail_q <= ld_fail;
			olast_q <= ld_last;
		end
	end

	// line stack, registered read
	always_ff @(posedge clk) begin
		if (push) begin
			stack_mem[depth_q[IDX_W-1:0]] <= line_q;
		end
		if (cmd.pop_rd) begin
			rd_q <= stack_mem[depth_dec[IDX_W-1:0]];
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = ev_q;
	assign m_tlast  = olast_q;
	assign m_tdata  = {{(OUT_TDATA_W-CHAR_W-LINE_OUT_W-ERR_W-1){1'b0}},
		ofail_q, oerr_q, oline_q, char_q};

endmodule

/* rtl/bracket_checking_tokenizer_unit.sv */
// Bracket-checking tokenizer. Takes one source byte per input item and flags
// nesting errors (unmatched ']', unclosed '[', too deep), invalid characters
// and too many errors. An ordinary byte is taken whenever the output register
// is free; a byte with two results (unmatched ']' or error-limit abort) holds
// input until its second result is loaded. The end-of-text item is taken,
// then, unless the block has halted, each unclosed '[' gets a registered stack
// read followed by an output load, and last the summary is loaded, all paced
// by the single output register. Configuration writes are always taken.
// top level: joins bct_ctrl and bct_dp; uses bct_pkg
module bracket_checking_tokenizer_unit #(
	parameter int STACK_DEPTH = bct_pkg::DEF_STACK_DEPTH,
	parameter int LINE_BITS   = bct_pkg::DEF_LINE_BITS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [bct_pkg::IN_TDATA_W-1:0]   s_tdata,  // [7:0] source_byte
	input  logic                             s_tlast,  // end_of_text
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// [7:0] character, [31:8] line_number, [47:32] errors_so_far, [48] failed
	output logic [bct_pkg::OUT_TDATA_W-1:0]  m_tdata,
	output logic [bct_pkg::OUT_TUSER_W-1:0]  m_tuser,  // [2:0] event_res
	output logic                             m_tlast,  // last
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [bct_pkg::CFG_W-1:0]        cfg_data  // max_errors
);
	import bct_pkg::*;

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	bct_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tlast  (s_tlast),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	bct_dp #(
		.STACK_DEPTH (STACK_DEPTH),
		.LINE_BITS   (LINE_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

/* test/tb_bracket_checking_tokenizer_unit.sv */
// Self-checking testbench for bracket_checking_tokenizer_unit: streams source
// bytes, predicts every event, and compares each result as it leaves the block.
// Depends on bct_pkg and the tokenizer RTL only.
`timescale 1ns / 1ps

module tb_bracket_checking_tokenizer_unit;
	import bct_pkg::*;

	localparam int WATCHDOG_CYCLES = 1000;
	localparam int NEST_LIMIT      = DEF_STACK_DEPTH;

	typedef struct {
		logic [EV_W-1:0]       kind;
		logic [CHAR_W-1:0]     ch;
		logic [LINE_OUT_W-1:0] line;
		logic [ERR_W-1:0]      errs;
		logic                  failed;
		logic                  last;
	} lex_result_t;

	logic clk;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_TDATA_W-1:0] s_tdata = '0;  // [7:0] source_byte
	logic s_tlast = 1'b0;                 // end_of_text
	logic m_tvalid;
	logic m_tready = 1'b0;
	// [7:0] character, [31:8] line_number, [47:32] errors_so_far, [48] failed
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic [OUT_TUSER_W-1:0] m_tuser;      // [2:0] event_res
	logic m_tlast;                        // last
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_W-1:0] cfg_data = '0;      // max_errors

	bracket_checking_tokenizer_unit dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	// predicted tokenizer state
	logic [CFG_W-1:0]      error_limit = MAX_ERRORS_RESET;
	logic                  in_comment = 1'b0;
	logic                  halted = 1'b0;
	logic [DEF_LINE_BITS-1:0] cur_line = DEF_LINE_BITS'(1);
	logic [ERR_W-1:0]      err_total = '0;
	logic [DEF_LINE_BITS-1:0] open_lines [NEST_LIMIT];
	int                    nest_depth = 0;

	lex_result_t pending_events[$];

	int mismatch_count = 0;
	int n_items = 0;
	int n_events = 0;
	int n_programs = 0;
	int n_limit_aborts = 0;
	int n_depth_aborts = 0;
	int deepest = 0;
	int idle_cycles = 0;

	// receiver and sender pacing
	bit idle_on = 1'b1;
	bit calm = 1'b0;
	int hold_off = 0;
	int stall_left = 0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic lex_result_t make_event(logic [EV_W-1:0] kind, logic [CHAR_W-1:0] ch,
			logic [DEF_LINE_BITS-1:0] ln);
		lex_result_t r;
		r.kind = kind;
		r.ch = ch;
		r.line = ln[LINE_OUT_W-1:0];
		r.errs = err_total;
		r.failed = 1'b0;
		r.last = 1'b0;
		return r;
	endfunction

	function automatic bit is_token_char(logic [CHAR_W-1:0] c);
		case (c)
			CH_GT, CH_LT, CH_PLUS, CH_MINUS, CH_DOT, CH_COMMA, CH_OPEN, CH_CLOSE: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	task automatic bump_errors();
		if (err_total != ERR_MAX)
			err_total++;
	endtask

	// work out the events one accepted item causes and queue them
	task automatic tokenize(input logic [CHAR_W-1:0] c, input logic eot);
		lex_result_t produced[$];
		lex_result_t r;
		if (eot) begin
			if (!halted) begin
				while (nest_depth > 0) begin
					nest_depth--;
					produced = {produced,
						make_event(EV_UNCLOSED, CH_OPEN, open_lines[nest_depth])};
				end
			end
			r = make_event(EV_SUMMARY, CH_NUL, cur_line);
			r.failed = halted || (err_total != 0) || (produced.size() > 0);
			produced = {produced, r};
			in_comment = 1'b0;
			halted = 1'b0;
			cur_line = DEF_LINE_BITS'(1);
			err_total = '0;
			nest_depth = 0;
		end else if (halted) begin
		end else if (in_comment) begin
			if (c == CH_NL) begin
				if (cur_line != '1)
					cur_line++;
				in_comment = 1'b0;
			end
		end else if (is_token_char(c)) begin
			if (c == CH_OPEN) begin
				if (nest_depth >= NEST_LIMIT) begin
					bump_errors();
					produced = {produced, make_event(EV_TOO_DEEP, c, cur_line)};
					halted = 1'b1;
				end else begin
					open_lines[nest_depth] = cur_line;
					nest_depth++;
					if (nest_depth > deepest)
						deepest = nest_depth;
					produced = {produced, make_event(EV_TOKEN, c, cur_line)};
				end
			end else if (c == CH_CLOSE) begin
				produced = {produced, make_event(EV_TOKEN, c, cur_line)};
				if (nest_depth > 0) begin
					nest_depth--;
				end else begin
					bump_errors();
					produced = {produced, make_event(EV_UNMATCHED, c, cur_line)};
				end
			end else begin
				produced = {produced, make_event(EV_TOKEN, c, cur_line)};
			end
		end else if (c == CH_SPACE || c == CH_TAB) begin
		end else if (c == CH_NL) begin
			if (cur_line != '1)
				cur_line++;
		end else if (c == CH_HASH) begin
			in_comment = 1'b1;
		end else begin
			bump_errors();
			produced = {produced, make_event(EV_INVALID, c, cur_line)};
			if (err_total > ERR_W'(error_limit)) begin
				produced = {produced, make_event(EV_TOO_MANY, c, cur_line)};
				halted = 1'b1;
			end
		end
		if (produced.size() > 0)
			produced[produced.size() - 1].last = 1'b1;
		foreach (produced[i])
			pending_events = {pending_events, produced[i]};
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch %s: got 0x%0h, want 0x%0h at %0t", what, got, want, $realtime);
		mismatch_count++;
	endtask

	// checks results, feeds the predictor, tracks config writes, and watches for a hang
	always @(posedge clk) begin : monitor
		lex_result_t want;
		if (m_tvalid && m_tready) begin
			n_events++;
			if (pending_events.size() == 0) begin
				report_mismatch("result with nothing expected, kind", 32'(m_tuser), 32'd0);
			end else begin
				want = pending_events.pop_front();
				if (m_tuser[2:0] != want.kind)
					report_mismatch("event kind", 32'(m_tuser[2:0]), 32'(want.kind));
				if (m_tdata[7:0] != want.ch)
					report_mismatch("character", 32'(m_tdata[7:0]), 32'(want.ch));
				if (m_tdata[31:8] != want.line)
					report_mismatch("line number", 32'(m_tdata[31:8]), 32'(want.line));
				if (m_tdata[47:32] != want.errs)
					report_mismatch("error count", 32'(m_tdata[47:32]), 32'(want.errs));
				if (m_tdata[48] != want.failed)
					report_mismatch("failed flag", 32'(m_tdata[48]), 32'(want.failed));
				if (m_tlast != want.last)
					report_mismatch("last flag", 32'(m_tlast), 32'(want.last));
				if (want.kind == EV_TOO_MANY)
					n_limit_aborts++;
				if (want.kind == EV_TOO_DEEP)
					n_depth_aborts++;
			end
		end
		if (s_tvalid && s_tready) begin
			n_items++;
			tokenize(s_tdata[7:0], s_tlast);
		end
		if (cfg_valid && cfg_ready)
			error_limit = cfg_data;
		if ((m_tvalid && m_tready) || (s_tvalid && s_tready) || (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_CYCLES) begin
			$display("watchdog: no item moved for %0d cycles, %0d events outstanding",
				idle_cycles, pending_events.size());
			$display("FAILURE");
			$finish;
		end
	end

	// receiver: long hold-off on request, random stall bursts otherwise
	initial begin
		forever begin
			@(negedge clk);
			if (hold_off > 0) begin
				m_tready <= 1'b0;
				hold_off--;
			end else if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else if (idle_on && !calm && $urandom_range(0, 7) == 0) begin
				m_tready <= 1'b0;
				stall_left = $urandom_range(0, 13);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// present one item and hold it until taken; valid stays up for a following item
	task automatic send_item(input logic [7:0] c, input logic eot);
		int gap;
		@(negedge clk);
		if (idle_on && !calm && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 14);
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= c;
		s_tlast <= eot;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic input_idle();
		@(negedge clk);
		s_tvalid <= 1'b0;
	endtask

	// let every predicted event drain, then give silent items time to settle
	task automatic wait_idle();
		input_idle();
		while (pending_events.size() != 0)
			@(posedge clk);
		repeat (10) @(negedge clk);
	endtask

	task automatic write_limit(input logic [CFG_W-1:0] v);
		wait_idle();
		cfg_data <= v;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [7:0] pick_plain();
		case ($urandom_range(0, 5))
			0: return CH_GT;
			1: return CH_LT;
			2: return CH_PLUS;
			3: return CH_MINUS;
			4: return CH_DOT;
			default: return CH_COMMA;
		endcase
	endfunction

	function automatic logic [7:0] pick_blank();
		case ($urandom_range(0, 2))
			0: return CH_SPACE;
			1: return CH_TAB;
			default: return CH_NL;
		endcase
	endfunction

	// mostly well-formed text with random content, a share of raw noise, then end marker
	task automatic send_program(input int len, input int noise_pct);
		int nest;
		int r;
		nest = 0;
		for (int i = 0; i < len; i++) begin
			r = $urandom_range(0, 99);
			if (r < noise_pct) begin
				send_item(8'($urandom_range(0, 255)), 1'b0);
			end else if (r < 45) begin
				send_item(pick_plain(), 1'b0);
			end else if (r < 58 && nest < 24) begin
				send_item(CH_OPEN, 1'b0);
				nest++;
			end else if (r < 70 && nest > 0) begin
				send_item(CH_CLOSE, 1'b0);
				nest--;
			end else if (r < 86) begin
				send_item(pick_blank(), 1'b0);
			end else if (r < 93) begin
				send_item(CH_HASH, 1'b0);
				repeat ($urandom_range(0, 4))
					send_item(8'($urandom_range(0, 255)), 1'b0);
				send_item(CH_NL, 1'b0);
			end else begin
				// may well be unmatched
				send_item(CH_CLOSE, 1'b0);
				if (nest > 0)
					nest--;
			end
		end
		if ($urandom_range(0, 3) != 0) begin
			while (nest > 0) begin
				send_item(CH_CLOSE, 1'b0);
				nest--;
			end
		end
		send_item(8'($urandom_range(0, 255)), 1'b1);
		n_programs++;
	endtask

	task automatic test_directed();
		logic [7:0] seq [$];
		seq = '{CH_GT, CH_LT, CH_PLUS, CH_MINUS, CH_DOT, CH_COMMA, CH_OPEN, CH_CLOSE,
			CH_SPACE, CH_TAB, CH_NL, CH_HASH, 8'h78, CH_CLOSE, CH_NL, CH_CLOSE,
			8'h00, 8'hFF, CH_OPEN, CH_NL, CH_OPEN};
		foreach (seq[i])
			send_item(seq[i], 1'b0);
		// end marker with two open brackets still on the stack
		send_item(8'hFF, 1'b1);
		// end marker on clean state, and one that also closes a comment
		send_item(CH_PLUS, 1'b0);
		send_item(8'h00, 1'b1);
		send_item(CH_HASH, 1'b0);
		send_item(8'h41, 1'b1);
	endtask

	task automatic test_error_limit();
		// limit 0: the first invalid byte aborts, later bytes are ignored
		write_limit(8'd0);
		send_item(8'h7F, 1'b0);
		send_item(CH_PLUS, 1'b0);
		send_item(CH_OPEN, 1'b0);
		send_item(8'h61, 1'b0);
		send_item(8'h00, 1'b1);
		// unmatched closes count toward the limit, checked on the next invalid byte
		write_limit(8'd3);
		send_item(CH_OPEN, 1'b0);
		send_item(8'h80, 1'b0);
		send_item(8'h01, 1'b0);
		send_item(CH_CLOSE, 1'b0);
		send_item(CH_CLOSE, 1'b0);
		send_item(CH_NL, 1'b0);
		send_item(8'hFE, 1'b0);
		send_item(CH_CLOSE, 1'b0);
		send_item(8'h00, 1'b1);
		write_limit(8'd255);
		send_program(30, 20);
	endtask

	task automatic test_deep_nesting();
		// full stack flushed at the end marker: the largest burst of events
		for (int i = 0; i < NEST_LIMIT; i++) begin
			send_item(CH_OPEN, 1'b0);
			if (i % 3 == 2)
				send_item(CH_NL, 1'b0);
		end
		send_item(8'h00, 1'b1);
		// one more open than the stack holds halts the block
		for (int i = 0; i <= NEST_LIMIT; i++)
			send_item(CH_OPEN, 1'b0);
		send_item(CH_MINUS, 1'b0);
		send_item(CH_CLOSE, 1'b0);
		send_item(8'h00, 1'b1);
	endtask

	task automatic test_backpressure();
		idle_on = 1'b0;
		hold_off = 300;
		for (int i = 0; i < 40; i++)
			send_item((i % 7 == 6) ? CH_CLOSE : pick_plain(), 1'b0);
		send_item(8'h00, 1'b1);
		idle_on = 1'b1;
	endtask

	task automatic test_random_programs();
		int v;
		while (n_items < 400) begin
			if ($urandom_range(0, 2) == 0) begin
				case ($urandom_range(0, 3))
					0: v = 0;
					1: v = 255;
					2: v = $urandom_range(0, 8);
					default: v = $urandom_range(0, 255);
				endcase
				write_limit(CFG_W'(v));
			end
			idle_on = ($urandom_range(0, 3) != 0);
			send_program($urandom_range(1, 40), ($urandom_range(0, 4) == 0) ? 30 : 4);
		end
		idle_on = 1'b1;
	endtask

	task automatic test_no_idling();
		write_limit(MAX_ERRORS_RESET);
		calm = 1'b1;
		send_program(40, 5);
		send_program(10, 50);
	endtask

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_error_limit();
		test_deep_nesting();
		test_backpressure();
		test_random_programs();
		test_no_idling();
		input_idle();
		while (pending_events.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		$display("tokenizer run: %0d source items in %0d programs, %0d events checked",
			n_items, n_programs, n_events);
		$display("error-limit aborts %0d, nesting aborts %0d, deepest nesting %0d",
			n_limit_aborts, n_depth_aborts, deepest);
		if (mismatch_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

/* files.f */
rtl/bct_pkg.sv
rtl/bct_ctrl.sv
rtl/bct_dp.sv
rtl/bracket_checking_tokenizer_unit.sv
test/tb_bracket_checking_tokenizer_unit.sv
